>>> design/i8bsd_pkg.sv
package i8bsd_pkg;

	// block geometry
	localparam int BLOCK_LEN  = 32;
	localparam int LANES      = 4;
	localparam int LANE_BYTES = BLOCK_LEN / LANES;
	localparam int PROD_W     = 16;
	localparam int LANE_SUM_W = 19;
	localparam int DOT_W      = 21;

	// float datapath geometry
	localparam int MAG_W     = 24;
	localparam int EXP_W     = 12;
	localparam int WIN_W     = 81;
	localparam int SH_W      = $clog2(WIN_W);
	localparam int P_PAD     = WIN_W - 1 - 2 * MAG_W;
	localparam int C_PAD     = WIN_W - 1 - MAG_W;
	localparam int NORM_STEP = 16;
	localparam int LZ_W      = $clog2(NORM_STEP + 1);

	localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;
	localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;

	// register map (word index)
	localparam logic [0:0] REG_ADD_TO_OUTPUT = 1'b0;

	typedef struct packed {
		logic zero;
		logic inf;
		logic nan;
	} fcls_t;

	// value = (-1)^sign * mag * 2^exp, unless a special class is set
	typedef struct packed {
		logic                    sign;
		fcls_t                   cls;
		logic [MAG_W-1:0]        mag;
		logic signed [EXP_W-1:0] exp;
	} fop_t;

	// request to the multiply-add unit: round(a * b + c)
	typedef struct packed {
		fop_t        a;
		logic [31:0] b;
		logic [31:0] c;
	} fma_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MERGE,
		S_MUL,
		S_MUL_WAIT,
		S_ACC,
		S_ACC_WAIT,
		S_ADD,
		S_ADD_WAIT,
		S_OUT
	} seq_state_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_ALIGN,
		F_ADD,
		F_NORM,
		F_DENORM,
		F_ROUND,
		F_DONE
	} fma_state_t;

	// split a single into sign, integer significand and exponent
	function automatic fop_t f32_unpack(input logic [31:0] w);
		fop_t r;
		r.sign     = w[31];
		r.cls.nan  = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
		r.cls.inf  = (w[30:23] == 8'hFF) && (w[22:0] == 23'd0);
		r.cls.zero = (w[30:0] == 31'd0);
		if (w[30:23] == 8'd0) begin
			r.mag = {1'b0, w[22:0]};
			r.exp = -12'sd149;
		end else begin
			r.mag = {1'b1, w[22:0]};
			r.exp = $signed({4'd0, w[30:23]}) - 12'sd150;
		end
		return r;
	endfunction

endpackage

>>> design/int8_block_scaled_dot_product.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------------------
// block in | blk_valid / blk_stall  | act_lanes_0..3, wgt_lanes_0..3, scales, c_in, last_block
// result   | res_valid / res_stall  | dot_result
// config   | APB psel/penable/pwrite| paddr, pwdata, prdata, pready (always high)
//
// A new item is accepted only once the sequencer is back in idle. The shared
// multiply-add unit runs twice per item (scale product, then accumulate);
// its normalize loop works in 16-bit steps. A last block ends in the output state,
// after a third pass (accumulator + c_in) when add_to_output is set.
// Reset clears the sequencer, the accumulator (+0.0) and sets add_to_output.
// A waiting result is held in the output register while the next item is taken in.
module int8_block_scaled_dot_product (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        blk_valid,
	output logic        blk_stall,
	input  logic [63:0] act_lanes_0,
	input  logic [63:0] act_lanes_1,
	input  logic [63:0] act_lanes_2,
	input  logic [63:0] act_lanes_3,
	input  logic [63:0] wgt_lanes_0,
	input  logic [63:0] wgt_lanes_1,
	input  logic [63:0] wgt_lanes_2,
	input  logic [63:0] wgt_lanes_3,
	input  logic [31:0] scale_act,
	input  logic [31:0] scale_wgt,
	input  logic [31:0] c_in,
	input  logic        last_block,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] dot_result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import i8bsd_pkg::*;

	seq_state_t state_q, state_d;

	logic [63:0]                  act_w [LANES];
	logic [63:0]                  wgt_w [LANES];
	logic signed [LANE_SUM_W-1:0] lane_sum_s1 [LANES];
	logic signed [DOT_W-1:0]      dot_d, dot_q;
	logic [DOT_W-1:0]             dot_abs;
	fop_t                         dot_op, one_op;

	logic [31:0] sa_q, sw_q, cin_q, fused_q, acc_q, res_q, dot_result_q;
	logic        last_q, add_q, res_valid_q;

	logic        blk_acc, res_acc, out_load, cfg_wr;
	logic        fma_start, fma_done;
	fma_req_t    fma_req;
	logic [31:0] fma_res;

	assign act_w[0] = act_lanes_0;
	assign act_w[1] = act_lanes_1;
	assign act_w[2] = act_lanes_2;
	assign act_w[3] = act_lanes_3;
	assign wgt_w[0] = wgt_lanes_0;
	assign wgt_w[1] = wgt_lanes_1;
	assign wgt_w[2] = wgt_lanes_2;
	assign wgt_w[3] = wgt_lanes_3;

	// byte-product lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		i8bsd_lane u_lane (
			.clk    (clk),
			.en     (blk_acc),
			.act    (act_w[g]),
			.wgt    (wgt_w[g]),
			.sum_s1 (lane_sum_s1[g])
		);
	end

	// merge lane sums
	always_comb begin
		dot_d = '0;
		for (int l = 0; l < LANES; l++) begin
			dot_d = dot_d + DOT_W'(lane_sum_s1[l]);
		end
	end

	// integer operands for the multiply-add unit
	always_comb begin
		dot_abs         = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
		dot_op.sign     = dot_q[DOT_W-1];
		dot_op.cls.zero = (dot_q == '0);
		dot_op.cls.inf  = 1'b0;
		dot_op.cls.nan  = 1'b0;
		dot_op.mag      = MAG_W'(dot_abs);
		dot_op.exp      = '0;
		one_op.sign     = 1'b0;
		one_op.cls      = '0;
		one_op.mag      = MAG_W'(1);
		one_op.exp      = '0;
	end

	i8bsd_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fma_start),
		.req    (fma_req),
		.done   (fma_done),
		.res    (fma_res)
	);

	assign blk_acc  = blk_valid && !blk_stall;
	assign res_acc  = res_valid_q && !res_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_load = (state_q == S_OUT) && (!res_valid_q || !res_stall);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (blk_acc) state_d = S_MERGE;
			S_MERGE:    state_d = S_MUL;
			S_MUL:      state_d = S_MUL_WAIT;
			S_MUL_WAIT: if (fma_done) state_d = S_ACC;
			S_ACC:      state_d = S_ACC_WAIT;
			S_ACC_WAIT: begin
				if (fma_done) begin
					if (!last_q) state_d = S_IDLE;
					else if (add_q) state_d = S_ADD;
					else state_d = S_OUT;
				end
			end
			S_ADD:      state_d = S_ADD_WAIT;
			S_ADD_WAIT: if (fma_done) state_d = S_OUT;
			S_OUT:      if (!res_valid_q || !res_stall) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		blk_stall = (state_q != S_IDLE);
		fma_start = 1'b0;
		fma_req   = '0;
		case (state_q)
			S_MUL: begin
				fma_start = 1'b1;
				fma_req.a = f32_unpack(sa_q);
				fma_req.b = sw_q;
				fma_req.c = F32_NEG_ZERO;
			end
			S_ACC: begin
				fma_start = 1'b1;
				fma_req.a = dot_op;
				fma_req.b = fused_q;
				fma_req.c = acc_q;
			end
			S_ADD: begin
				fma_start = 1'b1;
				fma_req.a = one_op;
				fma_req.b = acc_q;
				fma_req.c = cin_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= 32'd0;
			add_q       <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold config bit
			if (cfg_wr && (paddr[2] == REG_ADD_TO_OUTPUT)) begin
				add_q <= pwdata[0];
			end
			// advance accumulator, drop it once the result is out
			if ((state_q == S_ACC_WAIT) && fma_done) begin
				acc_q <= fma_res;
			end else if (out_load) begin
				acc_q <= 32'd0;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_acc) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (blk_acc) begin
			sa_q   <= scale_act;
			sw_q   <= scale_wgt;
			cin_q  <= c_in;
			last_q <= last_block;
		end
		if (state_q == S_MERGE) begin
			dot_q <= dot_d;
		end
		if ((state_q == S_MUL_WAIT) && fma_done) begin
			fused_q <= fma_res;
		end
		if ((state_q == S_ADD_WAIT) && fma_done) begin
			res_q <= fma_res;
		end
		if (out_load) begin
			dot_result_q <= add_q ? res_q : acc_q;
		end
	end

	assign res_valid  = res_valid_q;
	assign dot_result = dot_result_q;
	assign pready     = 1'b1;
	assign prdata     = (paddr[2] == REG_ADD_TO_OUTPUT) ? {31'd0, add_q} : 32'd0;

endmodule

>>> design/i8bsd_lane.sv
module i8bsd_lane (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [63:0]                            act,
	input  logic [63:0]                            wgt,
	output logic signed [i8bsd_pkg::LANE_SUM_W-1:0] sum_s1
);
	import i8bsd_pkg::*;

	logic signed [PROD_W-1:0]     prod [LANE_BYTES];
	logic signed [LANE_SUM_W-1:0] sum_d;

	// multiply byte pairs of this lane
	always_comb begin
		for (int k = 0; k < LANE_BYTES; k++) begin
			prod[k] = $signed(act[8*k +: 8]) * $signed(wgt[8*k +: 8]);
		end
	end

	// sum the lane's products
	always_comb begin
		sum_d = '0;
		for (int k = 0; k < LANE_BYTES; k++) begin
			sum_d = sum_d + LANE_SUM_W'(prod[k]);
		end
	end

	// capture on item accept
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_d;
		end
	end

endmodule

>>> design/i8bsd_fma.sv
module i8bsd_fma (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  i8bsd_pkg::fma_req_t   req,
	output logic                  done,
	output logic [31:0]           res
);
	import i8bsd_pkg::*;

	fma_state_t state_q, state_d;

	fop_t                    a_q, b_q, c_q;
	logic [31:0]             c_raw_q;
	logic [2*MAG_W-1:0]      p_mag_q;
	logic                    p_sign_q, p_nan_q, p_inf_q, p_zero_q;
	logic signed [EXP_W-1:0] tp_q, t_q, e_q;
	logic [WIN_W-1:0]        x_q, y_q, s_q, m_q;
	logic                    sub_q, r_sign_q;
	logic [7:0]              ef_q;
	logic [31:0]             res_q;

	logic signed [EXP_W-1:0] tc, dpc;
	logic                    c_first, nan_r, spec;
	logic [31:0]             spec_val;
	logic [WIN_W-1:0]        s_sum;
	logic                    s_sign, s_zero;
	logic [LZ_W-1:0]         lz;
	logic                    den, ovf;
	logic [MAG_W-1:0]        m24;
	logic                    guard, sticky, inc;
	logic [30:0]             pk;

	// shift right, folding the dropped bits into bit 0
	function automatic logic [WIN_W-1:0] rsh_sticky(input logic [WIN_W-1:0] x,
			input logic signed [EXP_W-1:0] amt);
		logic [WIN_W-1:0] mask;
		logic [WIN_W-1:0] r;
		mask = '0;
		if (int'(amt) >= WIN_W) begin
			r    = '0;
			r[0] = |x;
		end else if (int'(amt) <= 0) begin
			r = x;
		end else begin
			mask = (WIN_W'(1) << amt[SH_W-1:0]) - WIN_W'(1);
			r    = x >> amt[SH_W-1:0];
			r[0] = r[0] | (|(x & mask));
		end
		return r;
	endfunction

	// alignment and special operands
	always_comb begin
		tc       = c_q.exp + EXP_W'(MAG_W);
		c_first  = !c_q.cls.zero && (tc > tp_q);
		dpc      = c_first ? (tc - tp_q) : (tp_q - tc);
		nan_r    = p_nan_q || c_q.cls.nan || (p_inf_q && c_q.cls.inf && (p_sign_q != c_q.sign));
		spec     = 1'b1;
		spec_val = F32_QNAN;
		if (nan_r) begin
			spec_val = F32_QNAN;
		end else if (p_inf_q) begin
			spec_val = {p_sign_q, 8'hFF, 23'd0};
		end else if (c_q.cls.inf) begin
			spec_val = {c_q.sign, 8'hFF, 23'd0};
		end else if (p_zero_q) begin
			spec_val = c_q.cls.zero ? {p_sign_q & c_q.sign, 31'd0} : c_raw_q;
		end else begin
			spec = 1'b0;
		end
	end

	// signed magnitude add
	always_comb begin
		if (!sub_q) begin
			s_sum  = x_q + y_q;
			s_sign = p_sign_q;
		end else if (x_q >= y_q) begin
			s_sum  = x_q - y_q;
			s_sign = p_sign_q;
		end else begin
			s_sum  = y_q - x_q;
			s_sign = c_q.sign;
		end
	end

	// leading zeros in the top slice
	always_comb begin
		s_zero = (s_q == '0);
		lz     = LZ_W'(NORM_STEP);
		for (int i = 0; i < NORM_STEP; i++) begin
			if (s_q[WIN_W-NORM_STEP+i]) begin
				lz = LZ_W'(NORM_STEP - 1 - i);
			end
		end
	end

	// range checks and rounding
	always_comb begin
		den    = e_q < -12'sd126;
		ovf    = e_q > 12'sd127;
		m24    = m_q[WIN_W-1 -: MAG_W];
		guard  = m_q[WIN_W-1-MAG_W];
		sticky = |m_q[WIN_W-2-MAG_W:0];
		inc    = guard & (sticky | m24[0]);
		pk     = {ef_q, m24[MAG_W-2:0]} + 31'(inc);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE:   if (start) state_d = F_MUL;
			F_MUL:    state_d = F_ALIGN;
			F_ALIGN:  state_d = spec ? F_DONE : F_ADD;
			F_ADD:    state_d = F_NORM;
			F_NORM: begin
				if (s_zero) state_d = F_DONE;
				else if (s_q[WIN_W-1]) state_d = F_DENORM;
			end
			F_DENORM: state_d = ovf ? F_DONE : F_ROUND;
			F_ROUND:  state_d = F_DONE;
			F_DONE:   state_d = F_IDLE;
			default:  state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (state_q == F_DONE);
		res  = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath, one step per state
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (start) begin
					a_q     <= req.a;
					b_q     <= f32_unpack(req.b);
					c_q     <= f32_unpack(req.c);
					c_raw_q <= req.c;
				end
			end
			F_MUL: begin
				p_mag_q  <= a_q.mag * b_q.mag;
				p_sign_q <= a_q.sign ^ b_q.sign;
				p_nan_q  <= a_q.cls.nan | b_q.cls.nan |
					((a_q.cls.inf | b_q.cls.inf) & (a_q.cls.zero | b_q.cls.zero));
				p_inf_q  <= a_q.cls.inf | b_q.cls.inf;
				p_zero_q <= a_q.cls.zero | b_q.cls.zero;
				tp_q     <= a_q.exp + b_q.exp + EXP_W'(2 * MAG_W);
			end
			F_ALIGN: begin
				x_q   <= rsh_sticky({1'b0, p_mag_q, {P_PAD{1'b0}}},
					c_first ? dpc : EXP_W'(0));
				y_q   <= rsh_sticky({1'b0, c_q.mag, {C_PAD{1'b0}}},
					c_first ? EXP_W'(0) : dpc);
				t_q   <= c_first ? tc : tp_q;
				sub_q <= p_sign_q ^ c_q.sign;
				res_q <= spec_val;
			end
			F_ADD: begin
				s_q      <= s_sum;
				r_sign_q <= s_sign;
				e_q      <= t_q;
			end
			F_NORM: begin
				if (s_zero) begin
					res_q <= 32'd0;
				end else if (!s_q[WIN_W-1]) begin
					s_q <= s_q << lz;
					e_q <= e_q - EXP_W'(lz);
				end
			end
			F_DENORM: begin
				if (ovf) begin
					res_q <= {r_sign_q, 8'hFF, 23'd0};
				end else if (den) begin
					m_q  <= rsh_sticky(s_q, -12'sd126 - e_q);
					ef_q <= 8'd0;
				end else begin
					m_q  <= s_q;
					ef_q <= 8'(e_q + 12'sd127);
				end
			end
			F_ROUND: begin
				res_q <= {r_sign_q, pk};
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/i8bsd_checker.sv
module i8bsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        blk_valid,
	input logic        blk_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [31:0] dot_result
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(dot_result))
		else $error("stalled result changed");

	// one item at a time: stall follows an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && !blk_stall |=> blk_stall)
		else $error("item accepted while busy");

	// no result right after an item is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && !blk_stall |=> !$rose(res_valid))
		else $error("result appeared too early");

	// every NaN leaves as the canonical quiet NaN
	a_qnan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (dot_result[30:23] == 8'hFF) && (dot_result[22:0] != 23'd0)
		|-> dot_result == 32'h7FC0_0000)
		else $error("non-canonical NaN");

endmodule

bind int8_block_scaled_dot_product i8bsd_checker u_i8bsd_checker (.*);
